### rtl/core/rbpa_pkg.sv
`timescale 1ns / 1ps

package rbpa_pkg;

	// register indexes on the configuration port
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_BEEP_ON     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BEEP_GAP    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAUSE       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ALERT_WIN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BEEPS_CYCLE = 3'd4;
	localparam int unsigned CFG_DATA_W = 20;

	// reset values of the registers
	localparam logic [15:0] BEEP_ON_RST     = 16'd1000;
	localparam logic [15:0] BEEP_GAP_RST    = 16'd1000;
	localparam logic [15:0] PAUSE_RST       = 16'd2000;
	localparam logic [19:0] ALERT_WIN_RST   = 20'd7000;
	localparam logic [5:0]  BEEPS_CYCLE_RST = 6'd5;

	// fixed limits
	localparam logic [19:0] TEST_WINDOW_TICKS = 20'd4000;
	localparam logic [21:0] COOLDOWN_MAX      = 22'd3600000;
	localparam logic [15:0] ELAPSED_MAX       = 16'hFFFF;

	typedef enum logic [1:0] {
		ACT_TICK    = 2'd0,
		ACT_ALERT   = 2'd1,
		ACT_SILENCE = 2'd2,
		ACT_TEST    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		PH_ON    = 2'd0,
		PH_GAP   = 2'd1,
		PH_PAUSE = 2'd2
	} phase_t;

	typedef struct packed {
		logic [15:0] beep_on_ticks;
		logic [15:0] beep_gap_ticks;
		logic [15:0] pause_ticks;
		logic [19:0] alert_window_ticks;
		logic [5:0]  beeps_per_cycle;
	} cfg_t;

	typedef struct packed {
		logic        active;
		logic        pin_level;
		phase_t      phase;
		logic [5:0]  beep_count;
		logic [15:0] phase_elapsed;
		logic [19:0] window_left;
		logic [21:0] cooldown_left;
	} alarm_state_t;

	typedef struct packed {
		logic buzzer_on;
		logic alerting;
		logic in_cooldown;
		logic alert_ignored;
	} result_t;

endpackage

### rtl/core/rbpa_cfg.sv
`timescale 1ns / 1ps

module rbpa_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [rbpa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rbpa_pkg::CFG_DATA_W-1:0]  cfg_data,
	output rbpa_pkg::cfg_t                   cfg
);
	import rbpa_pkg::*;

	cfg_t cfg_q;

	// write one register per enabled cycle; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.beep_on_ticks      <= BEEP_ON_RST;
			cfg_q.beep_gap_ticks     <= BEEP_GAP_RST;
			cfg_q.pause_ticks        <= PAUSE_RST;
			cfg_q.alert_window_ticks <= ALERT_WIN_RST;
			cfg_q.beeps_per_cycle    <= BEEPS_CYCLE_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_BEEP_ON:     cfg_q.beep_on_ticks      <= cfg_data[15:0];
				REG_BEEP_GAP:    cfg_q.beep_gap_ticks     <= cfg_data[15:0];
				REG_PAUSE:       cfg_q.pause_ticks        <= cfg_data[15:0];
				REG_ALERT_WIN:   cfg_q.alert_window_ticks <= cfg_data[19:0];
				REG_BEEPS_CYCLE: cfg_q.beeps_per_cycle    <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/core/rbpa_step.sv
`timescale 1ns / 1ps

module rbpa_step (
	input  rbpa_pkg::alarm_state_t state_cur,
	input  rbpa_pkg::cfg_t         cfg,
	input  logic [1:0]             action,
	input  logic [21:0]            cooldown_ticks,
	output rbpa_pkg::alarm_state_t state_nxt,
	output rbpa_pkg::result_t      result
);
	import rbpa_pkg::*;

	always_comb begin
		alarm_state_t st;
		logic         ignored;
		logic [5:0]   cnt_inc;

		st      = state_cur;
		ignored = 1'b0;

		// apply the event
		unique case (action_t'(action))
			ACT_TICK: begin
				if (st.cooldown_left != '0)
					st.cooldown_left = st.cooldown_left - 22'd1;
				if (st.window_left != '0)
					st.window_left = st.window_left - 20'd1;
				if (st.active && st.phase_elapsed != ELAPSED_MAX)
					st.phase_elapsed = st.phase_elapsed + 16'd1;
			end
			ACT_ALERT: begin
				if (st.cooldown_left != '0) begin
					ignored = 1'b1;
				end else begin
					st.window_left = cfg.alert_window_ticks;
					if (!st.active) begin
						st.active        = 1'b1;
						st.beep_count    = '0;
						st.phase         = PH_ON;
						st.phase_elapsed = '0;
						st.pin_level     = 1'b1;
					end
				end
			end
			ACT_SILENCE: begin
				st.cooldown_left = (cooldown_ticks > COOLDOWN_MAX) ? COOLDOWN_MAX
				                                                    : cooldown_ticks;
				st.active    = 1'b0;
				st.pin_level = 1'b0;
			end
			ACT_TEST: begin
				if (!st.active) begin
					st.active        = 1'b1;
					st.beep_count    = '0;
					st.phase         = PH_ON;
					st.phase_elapsed = '0;
					st.pin_level     = 1'b1;
					st.window_left   = TEST_WINDOW_TICKS;
				end else if (st.window_left < TEST_WINDOW_TICKS) begin
					st.window_left = TEST_WINDOW_TICKS;
				end
			end
			default: ;
		endcase

		// stop when the window runs out
		if (st.active && st.window_left == '0) begin
			st.active    = 1'b0;
			st.pin_level = 1'b0;
		end

		// check the current phase once against its length
		cnt_inc = st.beep_count + 6'd1;
		if (st.active) begin
			unique case (st.phase)
				PH_ON: begin
					if (st.phase_elapsed >= cfg.beep_on_ticks) begin
						st.pin_level     = 1'b0;
						st.beep_count    = cnt_inc;
						st.phase         = (cnt_inc >= cfg.beeps_per_cycle) ? PH_PAUSE
						                                                    : PH_GAP;
						st.phase_elapsed = '0;
					end
				end
				PH_GAP: begin
					if (st.phase_elapsed >= cfg.beep_gap_ticks) begin
						st.pin_level     = 1'b1;
						st.phase         = PH_ON;
						st.phase_elapsed = '0;
					end
				end
				PH_PAUSE: begin
					if (st.phase_elapsed >= cfg.pause_ticks) begin
						st.beep_count    = '0;
						st.pin_level     = 1'b1;
						st.phase         = PH_ON;
						st.phase_elapsed = '0;
					end
				end
				default: begin
					// unused code: end of a pause
					st.beep_count    = '0;
					st.pin_level     = 1'b1;
					st.phase         = PH_ON;
					st.phase_elapsed = '0;
				end
			endcase
		end else begin
			st.pin_level = 1'b0;
		end

		state_nxt            = st;
		result.buzzer_on     = st.pin_level;
		result.alerting      = st.active;
		result.in_cooldown   = (st.cooldown_left != '0);
		result.alert_ignored = ignored;
	end

endmodule

### rtl/core/retriggerable_beep_pattern_alarm.sv
`timescale 1ns / 1ps

// An input transfer goes to the input register; its result then to the output register.
// Throughput: one item per cycle unless out_ready stalls; state_q loops via rbpa_step.
// The input register takes a new item while a result still waits at the output.
// Reset (arst_n low, asynchronous): alarm idle, pin level low, no cooldown,
// registers at their defaults, both pipeline stages empty.

module retriggerable_beep_pattern_alarm (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [rbpa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rbpa_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       action,
	input  logic [21:0]                      cooldown_ticks,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             buzzer_on,
	output logic                             alerting,
	output logic                             in_cooldown,
	output logic                             alert_ignored
);
	import rbpa_pkg::*;

	cfg_t         cfg;
	alarm_state_t state_q;
	alarm_state_t state_nxt;
	result_t      result;
	result_t      result_q;
	logic         valid_s1;
	logic [1:0]   action_s1;
	logic [21:0]  cooldown_s1;
	logic         out_valid_q;
	logic         advance;

	rbpa_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rbpa_step u_step (
		.state_cur      (state_q),
		.cfg            (cfg),
		.action         (action_s1),
		.cooldown_ticks (cooldown_s1),
		.state_nxt      (state_nxt),
		.result         (result)
	);

	// move the held item on when the output register is free or drains
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1   <= action;
			cooldown_s1 <= cooldown_ticks;
		end
	end

	// alarm state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.active        <= 1'b0;
			state_q.pin_level     <= 1'b0;
			state_q.phase         <= PH_ON;
			state_q.beep_count    <= '0;
			state_q.phase_elapsed <= '0;
			state_q.window_left   <= '0;
			state_q.cooldown_left <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (advance)
			result_q <= result;
	end

	assign out_valid     = out_valid_q;
	assign buzzer_on     = result_q.buzzer_on;
	assign alerting      = result_q.alerting;
	assign in_cooldown   = result_q.in_cooldown;
	assign alert_ignored = result_q.alert_ignored;

endmodule
